// File: rtl/core/lss_pkg.sv
package lss_pkg;

    localparam int MAX_LINE_SAMPLES_DEF = 4096;
    localparam int MAX_LINES_DEF = 65536;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BIT_DEPTH        = 3'd0,
        CFG_SHIFT_ENABLE     = 3'd1,
        CFG_SAMPLES_PER_LINE = 3'd2,
        CFG_LINES_PER_BUFFER = 3'd3,
        CFG_LINE_SELECT      = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL_N,
        B_MUL_SUM,
        B_DIV_VAR,
        B_SQRT,
        B_DIV_MEAN,
        B_FINISH
    } back_state_t;

    typedef struct packed {
        logic [31:0] sample;
        logic        start_of_buffer;
        logic [31:0] buffer_id;
    } in_item_t;

    typedef struct packed {
        logic [15:0] line_used;
        logic [31:0] min_value;
        logic [31:0] max_value;
        logic [47:0] mean_q16;
        logic [47:0] std_dev_q16;
        logic [31:0] buffer_tag;
    } out_item_t;

endpackage

// File: rtl/core/lss_front.sv
module lss_front #(
    parameter int MAX_LINE_SAMPLES = lss_pkg::MAX_LINE_SAMPLES_DEF,
    parameter int MAX_LINES = lss_pkg::MAX_LINES_DEF,
    parameter int REQ_W = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  lss_pkg::in_item_t                  item,
    input  logic                               cfg_write,
    input  logic [lss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lss_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               req_push,
    output logic [REQ_W-1:0]                   req_data
);
    import lss_pkg::*;

    localparam int NW = $clog2(MAX_LINE_SAMPLES + 1);
    localparam int CW = $clog2(MAX_LINE_SAMPLES);
    localparam int RW = $clog2(MAX_LINES);
    localparam int LW = $clog2(MAX_LINES + 1);
    localparam int SUMW = 32 + CW;
    localparam int SQW = 64 + CW;

    typedef struct packed {
        logic [15:0]     line;
        logic [31:0]     min_v;
        logic [31:0]     max_v;
        logic [SUMW-1:0] sum;
        logic [SQW-1:0]  sq;
        logic [NW-1:0]   n;
        logic [31:0]     tag;
    } req_t;

    logic [5:0]  bit_depth_reg;
    logic        shift_enable_reg;
    logic [12:0] samples_per_line_reg;
    logic [16:0] lines_per_buffer_reg;
    logic [15:0] line_select_reg;

    logic [CW-1:0]   column_reg, column_next, column_eff;
    logic [RW-1:0]   row_reg, row_next, row_eff;
    logic            done_reg, done_next, done_eff;
    logic [31:0]     min_reg, min_next;
    logic [31:0]     max_reg, max_next;
    logic [SUMW-1:0] sum_reg, sum_next;
    logic [SQW-1:0]  sq_reg, sq_next;
    logic [31:0]     tag_reg, tag_next;

    logic [NW-1:0] n_eff;
    logic [LW-1:0] lines_eff;
    logic [15:0]   sel;
    logic [31:0]   cond;
    logic [63:0]   square;
    logic          row_match;
    logic          last;
    req_t          req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg        <= 6'd16;
            shift_enable_reg     <= 1'b0;
            samples_per_line_reg <= 13'd1024;
            lines_per_buffer_reg <= 17'd65536;
            line_select_reg      <= 16'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BIT_DEPTH:        bit_depth_reg        <= cfg_data[5:0];
                CFG_SHIFT_ENABLE:     shift_enable_reg     <= cfg_data[0];
                CFG_SAMPLES_PER_LINE: samples_per_line_reg <= cfg_data[12:0];
                CFG_LINES_PER_BUFFER: lines_per_buffer_reg <= cfg_data[16:0];
                CFG_LINE_SELECT:      line_select_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (samples_per_line_reg == 13'd0)
            n_eff = NW'(1);
        else if (32'(samples_per_line_reg) > 32'(MAX_LINE_SAMPLES))
            n_eff = NW'(MAX_LINE_SAMPLES);
        else
            n_eff = NW'(samples_per_line_reg);

        if (lines_per_buffer_reg == 17'd0)
            lines_eff = LW'(1);
        else if (32'(lines_per_buffer_reg) > 32'(MAX_LINES))
            lines_eff = LW'(MAX_LINES);
        else
            lines_eff = LW'(lines_per_buffer_reg);

        if (32'(line_select_reg) > 32'(lines_eff) - 32'd1)
            sel = 16'(32'(lines_eff) - 32'd1);
        else
            sel = line_select_reg;

        if (bit_depth_reg <= 6'd8)
            cond = {24'd0, item.sample[7:0]};
        else if (bit_depth_reg <= 6'd16)
            cond = shift_enable_reg ? {20'd0, item.sample[15:4]} : {16'd0, item.sample[15:0]};
        else
            cond = item.sample;

        square = {32'd0, cond} * {32'd0, cond};

        column_eff = item.start_of_buffer ? '0 : column_reg;
        row_eff    = item.start_of_buffer ? '0 : row_reg;
        done_eff   = item.start_of_buffer ? 1'b0 : done_reg;
        tag_next   = item.start_of_buffer ? item.buffer_id : tag_reg;

        row_match = 32'(row_eff) == 32'(sel);
        last      = 32'(column_eff) >= 32'(n_eff) - 32'd1;

        if (column_eff == '0)
        begin
            min_next = '1;
            max_next = '0;
            sum_next = '0;
            sq_next  = '0;
        end
        else
        begin
            min_next = min_reg;
            max_next = max_reg;
            sum_next = sum_reg;
            sq_next  = sq_reg;
        end

        if (row_match)
        begin
            if (cond < min_next)
                min_next = cond;
            if (cond > max_next)
                max_next = cond;
            sum_next = sum_next + SUMW'(cond);
            sq_next  = sq_next + SQW'(square);
        end

        req_push  = accept && last && row_match && !done_eff;
        done_next = done_eff || req_push;

        if (last)
        begin
            column_next = '0;
            if (32'(row_eff) + 32'd1 >= 32'(lines_eff))
                row_next = '0;
            else
                row_next = row_eff + RW'(1);
        end
        else
        begin
            column_next = column_eff + CW'(1);
            row_next    = row_eff;
        end

        req.line  = sel;
        req.min_v = min_next;
        req.max_v = max_next;
        req.sum   = sum_next;
        req.sq    = sq_next;
        req.n     = n_eff;
        req.tag   = tag_next;
        req_data  = REQ_W'(req);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            done_reg   <= 1'b0;
            min_reg    <= '1;
            max_reg    <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
            tag_reg    <= '0;
        end
        else if (accept)
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            done_reg   <= done_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            sum_reg    <= sum_next;
            sq_reg     <= sq_next;
            tag_reg    <= tag_next;
        end
    end

endmodule

// File: rtl/core/lss_queue.sv
module lss_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = lss_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    import lss_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_reg, rd_reg;
    logic [KW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign full     = count_reg == KW'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (32'(wr_reg) == DEPTH - 1) ? '0 : wr_reg + PW'(1);
            if (do_pop)
                rd_reg <= (32'(rd_reg) == DEPTH - 1) ? '0 : rd_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + KW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - KW'(1);
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("queue count beyond depth");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + KW'(1))
        else $error("queue count did not grow on push");
    a_pop_legal: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("request taken from an empty queue");
`endif

endmodule

// File: rtl/core/lss_back.sv
module lss_back #(
    parameter int MAX_LINE_SAMPLES = lss_pkg::MAX_LINE_SAMPLES_DEF,
    parameter int FRACTION_BITS = lss_pkg::FRACTION_BITS_DEF,
    parameter int REQ_W = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  logic [REQ_W-1:0]   q_data,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output lss_pkg::out_item_t result
);
    import lss_pkg::*;

    localparam int NW = $clog2(MAX_LINE_SAMPLES + 1);
    localparam int CW = $clog2(MAX_LINE_SAMPLES);
    localparam int SUMW = 32 + CW;
    localparam int SQW = 64 + CW;
    localparam int DW = SQW + NW;
    localparam int NNW = 2 * NW;
    localparam int VW0 = DW + 2 * FRACTION_BITS;
    localparam int VW = VW0 + (VW0 % 2);
    localparam int HW = VW / 2;
    localparam int RMW = HW + 2;
    localparam int CNTW = $clog2(VW + 1);

    typedef struct packed {
        logic [15:0]     line;
        logic [31:0]     min_v;
        logic [31:0]     max_v;
        logic [SUMW-1:0] sum;
        logic [SQW-1:0]  sq;
        logic [NW-1:0]   n;
        logic [31:0]     tag;
    } req_t;

    back_state_t state_reg, state_next;
    req_t        req_reg, req_in;

    logic [DW-1:0]   prod_reg, t1_reg, mcand_reg, prod_step;
    logic [SUMW-1:0] mplier_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [VW-1:0]   div_reg, div_step;
    logic [NNW-1:0]  divisor_reg, r_reg, r_step;
    logic [NNW:0]    r_sh;
    logic            r_ge;
    logic [RMW-1:0]  rem_reg, rem_step, rem_sh, trial;
    logic [HW-1:0]   root_reg, root_step;
    logic [DW-1:0]   var_num;
    logic            res_valid_reg, res_free, res_load, step_last;

    assign req_in    = req_t'(q_data);
    assign res_free  = !res_valid_reg || pop;
    assign empty     = !res_valid_reg;
    assign step_last = cnt_reg == CNTW'(1);

    always_comb
    begin
        prod_step = prod_reg + (mplier_reg[0] ? mcand_reg : '0);
        var_num   = (t1_reg >= prod_step) ? t1_reg - prod_step : '0;

        r_sh     = {r_reg, div_reg[VW-1]};
        r_ge     = r_sh >= {1'b0, divisor_reg};
        r_step   = r_ge ? NNW'(r_sh - {1'b0, divisor_reg}) : r_sh[NNW-1:0];
        div_step = {div_reg[VW-2:0], r_ge};

        rem_sh = {rem_reg[RMW-3:0], div_reg[VW-1:VW-2]};
        trial  = {root_reg, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_step  = rem_sh - trial;
            root_step = {root_reg[HW-2:0], 1'b1};
        end
        else
        begin
            rem_step  = rem_sh;
            root_step = {root_reg[HW-2:0], 1'b0};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:     if (!q_empty) state_next = B_MUL_N;
            B_MUL_N:    if (step_last) state_next = B_MUL_SUM;
            B_MUL_SUM:  if (step_last) state_next = B_DIV_VAR;
            B_DIV_VAR:  if (step_last) state_next = B_SQRT;
            B_SQRT:     if (step_last) state_next = B_DIV_MEAN;
            B_DIV_MEAN: if (step_last) state_next = B_FINISH;
            B_FINISH:   if (res_free) state_next = B_IDLE;
            default:    state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = (state_reg == B_IDLE) && !q_empty;
        res_load = (state_reg == B_FINISH) && res_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (pop)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                req_reg     <= req_in;
                prod_reg    <= '0;
                mcand_reg   <= DW'(req_in.sq);
                mplier_reg  <= SUMW'(req_in.n);
                divisor_reg <= NNW'(req_in.n) * NNW'(req_in.n);
                cnt_reg     <= CNTW'(NW);
            end
            B_MUL_N:
            begin
                if (step_last)
                begin
                    t1_reg     <= prod_step;
                    prod_reg   <= '0;
                    mcand_reg  <= DW'(req_reg.sum);
                    mplier_reg <= req_reg.sum;
                    cnt_reg    <= CNTW'(SUMW);
                end
                else
                begin
                    prod_reg   <= prod_step;
                    mcand_reg  <= {mcand_reg[DW-2:0], 1'b0};
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg - CNTW'(1);
                end
            end
            B_MUL_SUM:
            begin
                if (step_last)
                begin
                    div_reg <= VW'(var_num) << (2 * FRACTION_BITS);
                    r_reg   <= '0;
                    cnt_reg <= CNTW'(VW);
                end
                else
                begin
                    prod_reg   <= prod_step;
                    mcand_reg  <= {mcand_reg[DW-2:0], 1'b0};
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg - CNTW'(1);
                end
            end
            B_DIV_VAR:
            begin
                div_reg <= div_step;
                r_reg   <= r_step;
                if (step_last)
                begin
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= CNTW'(HW);
                end
                else
                    cnt_reg <= cnt_reg - CNTW'(1);
            end
            B_SQRT:
            begin
                rem_reg  <= rem_step;
                root_reg <= root_step;
                if (step_last)
                begin
                    div_reg     <= VW'(req_reg.sum) << FRACTION_BITS;
                    divisor_reg <= NNW'(req_reg.n);
                    r_reg       <= '0;
                    cnt_reg     <= CNTW'(VW);
                end
                else
                begin
                    div_reg <= {div_reg[VW-3:0], 2'b00};
                    cnt_reg <= cnt_reg - CNTW'(1);
                end
            end
            B_DIV_MEAN:
            begin
                div_reg <= div_step;
                r_reg   <= r_step;
                cnt_reg <= cnt_reg - CNTW'(1);
            end
            B_FINISH:
            begin
                if (res_load)
                begin
                    result.line_used   <= req_reg.line;
                    result.min_value   <= req_reg.min_v;
                    result.max_value   <= req_reg.max_v;
                    result.mean_q16    <= 48'(div_reg);
                    result.std_dev_q16 <= 48'(root_reg);
                    result.buffer_tag  <= req_reg.tag;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/core/line_select_statistics_top.sv
// Samples are taken at one per cycle while full is low, and the line position is tracked with no
// gaps; full rises only while two finished line requests wait for the arithmetic back end. The
// back end works on one line request at a time, with the bit-serial multiplier, the shared
// one-bit-per-cycle divider and the two-bits-per-cycle square root, and a finished result waits
// in an output register until taken.
module line_select_statistics_top #(
    parameter int MAX_LINE_SAMPLES = lss_pkg::MAX_LINE_SAMPLES_DEF,
    parameter int MAX_LINES = lss_pkg::MAX_LINES_DEF,
    parameter int FRACTION_BITS = lss_pkg::FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  lss_pkg::in_item_t               item,
    output logic                            empty,
    input  logic                            pop,
    output lss_pkg::out_item_t              result,
    input  logic                            cfg_write,
    input  logic [lss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lss_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lss_pkg::*;

    localparam int NW = $clog2(MAX_LINE_SAMPLES + 1);
    localparam int CW = $clog2(MAX_LINE_SAMPLES);
    localparam int REQ_W = 16 + 32 + 32 + (32 + CW) + (64 + CW) + NW + 32;

    logic             accept;
    logic             req_push, q_pop, q_empty;
    logic [REQ_W-1:0] req_data, q_data;

    assign accept = push && !full;

    lss_front #(
        .MAX_LINE_SAMPLES(MAX_LINE_SAMPLES),
        .MAX_LINES(MAX_LINES),
        .REQ_W(REQ_W)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .item(item),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_push(req_push),
        .req_data(req_data)
    );

    lss_queue #(
        .WIDTH(REQ_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(req_push),
        .push_data(req_data),
        .pop(q_pop),
        .pop_data(q_data),
        .full(full),
        .empty(q_empty)
    );

    lss_back #(
        .MAX_LINE_SAMPLES(MAX_LINE_SAMPLES),
        .FRACTION_BITS(FRACTION_BITS),
        .REQ_W(REQ_W)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(q_empty),
        .q_data(q_data),
        .q_pop(q_pop),
        .pop(pop),
        .empty(empty),
        .result(result)
    );

endmodule
